FILE: rtl/quality_tail_trim_finder_unit_macros.svh
// Assertion macros used by the checker file qttf_checker.sv.
`ifndef QUALITY_TAIL_TRIM_FINDER_UNIT_MACROS_SVH
`define QUALITY_TAIL_TRIM_FINDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define QTTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qttf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define QTTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qttf assertion failed");

`endif

FILE: rtl/qttf_pkg.sv
`timescale 1ns / 1ps

package qttf_pkg;

    localparam int QUAL_W = 8;
    localparam int POS_W  = 20;
    localparam int IDX_W  = 21;
    localparam int LEN_W  = 21;
    localparam int SUM_W  = 26;
    localparam int SCR_W  = 6;
    localparam int CFG_W  = 21;
    localparam int CIDX_W = 3;
    localparam int STAT_W = 3;

    // Saturation floor of the running sum, -2^25
    localparam logic signed [SUM_W-1:0] SUM_FLOOR = {1'b1, {(SUM_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_LOW_THR  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HIGH_THR = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_MID_SCR  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_HIGH_SCR = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MIN_LEN  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_MIN_TRIM = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_TRIM       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_MUX    = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_SHORT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXCESSIVE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_LITTLE = 3'd4;

endpackage

FILE: rtl/quality_tail_trim_finder_unit.sv
// An accepted word at position 0 passes the input, read snapshot and result registers
// to o_out_valid. Throughput: one input word per cycle while o_in_stall is low; the
// running-sum update (add, compare with the minimum, select) sits between the input
// register and the read-state registers.
// Reset (synchronous, i_rst_n low): configuration returns to its defaults, read state
// to sum 0 / minimum -1, and all pipeline valids clear.
`timescale 1ns / 1ps

module quality_tail_trim_finder_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [qttf_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [qttf_pkg::CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [qttf_pkg::QUAL_W-1:0]        i_qual_char,
    input  logic [qttf_pkg::POS_W-1:0]         i_position,
    input  logic                               i_first_of_read,
    input  logic                               i_mux_change_end,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [qttf_pkg::IDX_W-1:0]  o_last_kept,
    output logic [qttf_pkg::STAT_W-1:0]        o_status
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [qttf_pkg::QUAL_W-1:0] r_low_thr, r_high_thr;
    logic [qttf_pkg::SCR_W-1:0]  r_mid_scr, r_high_scr;
    logic [qttf_pkg::LEN_W-1:0]  r_min_len, r_min_trim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= 8'd40;
            r_high_thr <= 8'd45;
            r_mid_scr  <= 6'd1;
            r_high_scr <= 6'd10;
            r_min_len  <= 21'd100;
            r_min_trim <= 21'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qttf_pkg::CFG_LOW_THR:  r_low_thr  <= i_cfg_data[qttf_pkg::QUAL_W-1:0];
                qttf_pkg::CFG_HIGH_THR: r_high_thr <= i_cfg_data[qttf_pkg::QUAL_W-1:0];
                qttf_pkg::CFG_MID_SCR:  r_mid_scr  <= i_cfg_data[qttf_pkg::SCR_W-1:0];
                qttf_pkg::CFG_HIGH_SCR: r_high_scr <= i_cfg_data[qttf_pkg::SCR_W-1:0];
                qttf_pkg::CFG_MIN_LEN:  r_min_len  <= i_cfg_data[qttf_pkg::LEN_W-1:0];
                qttf_pkg::CFG_MIN_TRIM: r_min_trim <= i_cfg_data[qttf_pkg::LEN_W-1:0];
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // s1: input register, s2: finished read (index, length, mux flag),
    // out: result register with status. Each stage moves when the next
    // one is empty or emptying this cycle.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_ov;
    logic w_out_free, w_s2_ready, w_adv1, w_adv2, w_in_acc, w_emit;

    assign w_out_free = !r_ov || !i_out_stall;
    assign w_adv2     = r_v2 && w_out_free;
    assign w_s2_ready = !r_v2 || w_out_free;
    assign w_adv1     = r_v1 && w_s2_ready;
    assign o_in_stall = r_v1 && !w_s2_ready;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [qttf_pkg::QUAL_W-1:0] r_s1_qual;
    logic [qttf_pkg::POS_W-1:0]  r_s1_pos;
    logic                        r_s1_first, r_s1_mux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_in_acc) begin
            r_v1 <= 1'b1;
        end else if (w_adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_qual  <= i_qual_char;
            r_s1_pos   <= i_position;
            r_s1_first <= i_first_of_read;
            r_s1_mux   <= i_mux_change_end;
        end
    end

    // ------------------------------------------------------------------
    // Read state update: scoring, running sum and minimum, argmin.
    // A first word restarts the read before being scored itself.
    // ------------------------------------------------------------------
    logic signed [qttf_pkg::SUM_W-1:0] r_sum, r_min;
    logic signed [qttf_pkg::IDX_W-1:0] r_best;
    logic [qttf_pkg::LEN_W-1:0]        r_len;
    logic                              r_stop, r_mux;

    logic signed [qttf_pkg::SUM_W-1:0] n_sum, n_min, w_b_sum, w_b_min, w_add, w_pos_ext;
    logic signed [qttf_pkg::IDX_W-1:0] n_best, w_b_best, w_pos_m1;
    logic [qttf_pkg::LEN_W-1:0]        n_len;
    logic                              n_stop, n_mux, w_b_stop;

    always_comb begin
        w_pos_ext = $signed({{(qttf_pkg::SUM_W-qttf_pkg::POS_W){1'b0}}, r_s1_pos});
        w_pos_m1  = $signed({1'b0, r_s1_pos}) - 21'sd1;

        w_b_sum  = r_s1_first ? '0 : r_sum;
        w_b_min  = r_s1_first ? -26'sd1 : r_min;
        w_b_best = r_s1_first ? $signed({1'b0, r_s1_pos}) : r_best;
        w_b_stop = r_s1_first ? 1'b0 : r_stop;
        n_len    = r_s1_first ? ({1'b0, r_s1_pos} + 21'd1) : r_len;
        n_mux    = r_s1_first ? r_s1_mux : r_mux;

        if (r_s1_qual <= r_low_thr) begin
            w_add = -26'sd1;
        end else if (r_s1_qual <= r_high_thr) begin
            w_add = $signed({{(qttf_pkg::SUM_W-qttf_pkg::SCR_W){1'b0}}, r_mid_scr});
        end else begin
            w_add = $signed({{(qttf_pkg::SUM_W-qttf_pkg::SCR_W){1'b0}}, r_high_scr});
        end

        n_sum  = w_b_sum;
        n_min  = w_b_min;
        n_best = w_b_best;
        n_stop = w_b_stop;
        if (!w_b_stop) begin
            // sum saturates at the floor on a low score
            if (w_add[qttf_pkg::SUM_W-1] && (w_b_sum <= qttf_pkg::SUM_FLOOR)) begin
                n_sum = qttf_pkg::SUM_FLOOR;
            end else begin
                n_sum = w_b_sum + w_add;
            end
            if (n_sum <= w_b_min) begin
                n_min  = n_sum;
                n_best = w_pos_m1;
            end
            n_stop = (n_sum > w_pos_ext);
        end
    end

    assign w_emit = (r_s1_pos == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_min  <= -26'sd1;
            r_best <= '0;
            r_len  <= '0;
            r_stop <= 1'b0;
            r_mux  <= 1'b0;
        end else if (w_adv1) begin
            r_sum  <= n_sum;
            r_min  <= n_min;
            r_best <= n_best;
            r_len  <= n_len;
            r_stop <= n_stop;
            r_mux  <= n_mux;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: snapshot of a finished read
    // ------------------------------------------------------------------
    logic signed [qttf_pkg::IDX_W-1:0] r_s2_idx;
    logic [qttf_pkg::LEN_W-1:0]        r_s2_len;
    logic                              r_s2_mux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv1 && w_emit) begin
            r_v2 <= 1'b1;
        end else if (w_adv2) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && w_emit) begin
            r_s2_idx <= n_best;
            r_s2_len <= n_len;
            r_s2_mux <= n_mux;
        end
    end

    // ------------------------------------------------------------------
    // Status: 10*(idx+1) <= 3*len is the fixed-point form of the 0.3 rule;
    // both products are shift-and-add.
    // ------------------------------------------------------------------
    logic signed [21:0] w_idx_p1;
    logic signed [26:0] w_idx_ext, w_lhs, w_rhs;
    logic signed [22:0] w_lim, w_idx23;
    logic [qttf_pkg::STAT_W-1:0] n_status;

    always_comb begin
        w_idx_p1  = $signed({r_s2_idx[qttf_pkg::IDX_W-1], r_s2_idx}) + 22'sd1;
        w_idx_ext = $signed({{5{w_idx_p1[21]}}, w_idx_p1});
        w_lhs     = (w_idx_ext <<< 3) + (w_idx_ext <<< 1);
        w_rhs     = $signed({6'b0, r_s2_len} << 1) + $signed({6'b0, r_s2_len});
        w_lim     = $signed({2'b0, r_s2_len}) - $signed({2'b0, r_min_trim});
        w_idx23   = $signed({{2{r_s2_idx[qttf_pkg::IDX_W-1]}}, r_s2_idx});

        if (!r_s2_mux) begin
            n_status = qttf_pkg::ST_NOT_MUX;
        end else if (r_s2_len < r_min_len) begin
            n_status = qttf_pkg::ST_TOO_SHORT;
        end else if (w_lhs <= w_rhs) begin
            n_status = qttf_pkg::ST_EXCESSIVE;
        end else if (w_idx23 >= w_lim) begin
            n_status = qttf_pkg::ST_TOO_LITTLE;
        end else begin
            n_status = qttf_pkg::ST_TRIM;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic signed [qttf_pkg::IDX_W-1:0] r_out_idx;
    logic [qttf_pkg::STAT_W-1:0]       r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv2) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_out_idx    <= r_s2_idx;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid = r_ov;
    assign o_last_kept = r_out_idx;
    assign o_status    = r_out_status;

endmodule

FILE: rtl/qttf_checker.sv
`timescale 1ns / 1ps
`include "quality_tail_trim_finder_unit_macros.svh"

module qttf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [qttf_pkg::IDX_W-1:0]  o_last_kept,
    input logic [qttf_pkg::STAT_W-1:0]        o_status
);

    logic w_out_held, w_trim_out;

    assign w_out_held = o_out_valid && i_out_stall;
    assign w_trim_out = o_out_valid && (o_status == qttf_pkg::ST_TRIM);

    // stalled result word stays and holds
    `QTTF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_held, o_out_valid)
    `QTTF_ASSERT_NEXT(a_idx_stable, i_clk, i_rst_n, w_out_held, $stable(o_last_kept))
    `QTTF_ASSERT_NEXT(a_status_stable, i_clk, i_rst_n, w_out_held, $stable(o_status))
    // only defined status codes
    `QTTF_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid, o_status <= qttf_pkg::ST_TOO_LITTLE)
    // a trim always keeps at least one base
    `QTTF_ASSERT_NOW(a_trim_idx, i_clk, i_rst_n, w_trim_out, !o_last_kept[qttf_pkg::IDX_W-1])

endmodule

bind quality_tail_trim_finder_unit qttf_checker u_qttf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_last_kept  (o_last_kept),
    .o_status     (o_status)
);
